[rtl/pdcsl_pkg.sv]
// shared widths, register indexes, reset values and stage enables for the pd controller
package pdcsl_pkg;

	localparam int ERR_W      = 16;
	localparam int DERR_W     = ERR_W + 1;
	localparam int GAIN_W     = 8;
	localparam int ACCEL_W    = 10;
	localparam int LIMIT_W    = 7;
	localparam int DRIVE_W    = 8;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 10;

	// gain products and their magnitudes
	localparam int PPROD_W = GAIN_W + ERR_W + 1;
	localparam int DPROD_W = GAIN_W + DERR_W + 1;
	localparam int MAG_W   = 24;

	// divide by 100: q = (x * RECIP) >> RECIP_SHIFT, exact for x below 2**MAG_W
	localparam int RECIP_W     = 25;
	localparam int RECIP_SHIFT = 31;
	localparam logic [RECIP_W-1:0] RECIP = 25'd21474837;
	localparam int SCALED_W = MAG_W + RECIP_W;
	localparam int QUOT_W   = 18;
	localparam int TERM_W   = QUOT_W + 1;
	localparam int CMD_W    = TERM_W + 1;
	localparam int DIFF_W   = CMD_W + 1;
	localparam int STEP_W   = ACCEL_W + 1;
	localparam int SUM_W    = STEP_W + 1;

	localparam logic [CFG_IDX_W-1:0] REG_PROP_GAIN   = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_DERIV_GAIN  = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_ACCEL_LIMIT = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_SPEED_LIMIT = 2'd3;

	localparam logic [GAIN_W-1:0]  PROP_GAIN_RST   = 8'd20;
	localparam logic [GAIN_W-1:0]  DERIV_GAIN_RST  = 8'd0;
	localparam logic [ACCEL_W-1:0] ACCEL_LIMIT_RST = 10'd300;
	localparam logic [LIMIT_W-1:0] SPEED_LIMIT_RST = 7'd127;

	// load enables of the pipeline registers, s1 is the input register
	typedef struct packed {
		logic s1;
		logic s2;
		logic s3;
		logic s4;
		logic res;
	} adv_t;

endpackage

[rtl/pd_controller_slew_limited.sv]
// two-axis pd controller with slew and speed limit: handshake, registers, pipeline control
// a result is offered after its item passes the input register, then the gain multiply,
// reciprocal divide, term sum and result register stages; throughput: one item per cycle,
// the pipeline stages fill while the result register waits and then stall the input
// reset: arst_n clears the item flags, kept errors and speeds and loads register defaults
module pd_controller_slew_limited (
	input  logic                                    clk,
	input  logic                                    arst_n,
	input  logic                                    cfg_wr_en,
	input  logic [pdcsl_pkg::CFG_IDX_W-1:0]         cfg_index,
	input  logic [pdcsl_pkg::CFG_DATA_W-1:0]        cfg_data,
	input  logic                                    in_valid,
	output logic                                    in_stall,
	input  logic signed [pdcsl_pkg::ERR_W-1:0]      error_x,
	input  logic signed [pdcsl_pkg::ERR_W-1:0]      error_y,
	output logic                                    out_valid,
	input  logic                                    out_stall,
	output logic signed [pdcsl_pkg::DRIVE_W-1:0]    drive_x,
	output logic signed [pdcsl_pkg::DRIVE_W-1:0]    drive_y
);
	import pdcsl_pkg::*;

	logic [GAIN_W-1:0]  prop_gain_q;
	logic [GAIN_W-1:0]  deriv_gain_q;
	logic [ACCEL_W-1:0] accel_limit_q;
	logic [LIMIT_W-1:0] speed_limit_q;

	logic   valid_s1;
	logic   valid_s2;
	logic   valid_s3;
	logic   valid_s4;
	logic   out_valid_q;
	logic   pop;
	adv_t   adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prop_gain_q   <= PROP_GAIN_RST;
			deriv_gain_q  <= DERIV_GAIN_RST;
			accel_limit_q <= ACCEL_LIMIT_RST;
			speed_limit_q <= SPEED_LIMIT_RST;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				REG_PROP_GAIN:   prop_gain_q   <= cfg_data[GAIN_W-1:0];
				REG_DERIV_GAIN:  deriv_gain_q  <= cfg_data[GAIN_W-1:0];
				REG_ACCEL_LIMIT: accel_limit_q <= cfg_data[ACCEL_W-1:0];
				REG_SPEED_LIMIT: speed_limit_q <= cfg_data[LIMIT_W-1:0];
				default: ;
			endcase
		end
	end

	// a stage loads when the one ahead is empty or moving on
	assign pop     = out_valid_q && !out_stall;
	assign adv.res = valid_s4 && (!out_valid_q || pop);
	assign adv.s4  = valid_s3 && (!valid_s4 || adv.res);
	assign adv.s3  = valid_s2 && (!valid_s3 || adv.s4);
	assign adv.s2  = valid_s1 && (!valid_s2 || adv.s3);
	assign in_stall = valid_s1 && !adv.s2;
	assign adv.s1  = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			valid_s2    <= 1'b0;
			valid_s3    <= 1'b0;
			valid_s4    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			valid_s1    <= adv.s1 || (valid_s1 && !adv.s2);
			valid_s2    <= adv.s2 || (valid_s2 && !adv.s3);
			valid_s3    <= adv.s3 || (valid_s3 && !adv.s4);
			valid_s4    <= adv.s4 || (valid_s4 && !adv.res);
			out_valid_q <= adv.res || (out_valid_q && !pop);
		end
	end

	assign out_valid = out_valid_q;

	pdcsl_axis u_axis_x (
		.clk         (clk),
		.arst_n      (arst_n),
		.adv         (adv),
		.error       (error_x),
		.prop_gain   (prop_gain_q),
		.deriv_gain  (deriv_gain_q),
		.accel_limit (accel_limit_q),
		.speed_limit (speed_limit_q),
		.drive       (drive_x)
	);

	pdcsl_axis u_axis_y (
		.clk         (clk),
		.arst_n      (arst_n),
		.adv         (adv),
		.error       (error_y),
		.prop_gain   (prop_gain_q),
		.deriv_gain  (deriv_gain_q),
		.accel_limit (accel_limit_q),
		.speed_limit (speed_limit_q),
		.drive       (drive_y)
	);

`ifndef SYNTHESIS
	// a result only appears when stage 4 held an item
	a_res_from_s4: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(valid_s4))
		else $error("result raised without an item in stage 4");

	// a waiting result keeps the item behind it in stage 4
	a_s4_held: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_stall && valid_s4) |=> valid_s4)
		else $error("item lost from stage 4 while result stalled");

	// full pipeline with a stalled result takes no new item
	a_full_stall: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_stall && valid_s4 && valid_s3 && valid_s2 && valid_s1)
		|-> in_stall)
		else $error("item accepted into a full pipeline");

	// kept speeds move only when a result is loaded
	a_speed_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!adv.res |=> ($stable(drive_x) && $stable(drive_y)))
		else $error("kept speed changed without a result load");
`endif

endmodule

[rtl/pdcsl_axis.sv]
// datapath of one axis: gains, divide by 100, acceleration and speed clamps
module pdcsl_axis (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  pdcsl_pkg::adv_t                      adv,
	input  logic signed [pdcsl_pkg::ERR_W-1:0]   error,
	input  logic [pdcsl_pkg::GAIN_W-1:0]         prop_gain,
	input  logic [pdcsl_pkg::GAIN_W-1:0]         deriv_gain,
	input  logic [pdcsl_pkg::ACCEL_W-1:0]        accel_limit,
	input  logic [pdcsl_pkg::LIMIT_W-1:0]        speed_limit,
	output logic signed [pdcsl_pkg::DRIVE_W-1:0] drive
);
	import pdcsl_pkg::*;

	logic signed [ERR_W-1:0]   prev_error_q;
	logic signed [ERR_W-1:0]   err_s1;
	logic signed [DERR_W-1:0]  derr_s1;
	logic signed [DERR_W-1:0]  derr_in;

	logic signed [PPROD_W-1:0] prop_prod;
	logic signed [DPROD_W-1:0] deriv_prod;
	logic [MAG_W-1:0]          prop_mag;
	logic [MAG_W-1:0]          deriv_mag;
	logic [MAG_W-1:0]          prop_mag_s2;
	logic [MAG_W-1:0]          deriv_mag_s2;
	logic                      prop_neg_s2;
	logic                      deriv_neg_s2;

	logic [SCALED_W-1:0]       prop_scaled;
	logic [SCALED_W-1:0]       deriv_scaled;
	logic [QUOT_W-1:0]         prop_quot_s3;
	logic [QUOT_W-1:0]         deriv_quot_s3;
	logic                      prop_neg_s3;
	logic                      deriv_neg_s3;

	logic signed [TERM_W-1:0]  prop_term;
	logic signed [TERM_W-1:0]  deriv_term;
	logic signed [CMD_W-1:0]   cmd;
	logic signed [CMD_W-1:0]   cmd_s4;

	logic signed [DIFF_W-1:0]  diff;
	logic signed [DIFF_W-1:0]  accel_pos;
	logic signed [STEP_W-1:0]  step;
	logic signed [SUM_W-1:0]   speed_sum;
	logic signed [SUM_W-1:0]   limit_pos;
	logic signed [DRIVE_W-1:0] speed_next;
	logic signed [DRIVE_W-1:0] speed_q;

	// error difference is taken against the last accepted item
	assign derr_in = {error[ERR_W-1], error} - {prev_error_q[ERR_W-1], prev_error_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_error_q <= '0;
		end else if (adv.s1) begin
			prev_error_q <= error;
		end
	end

	always_ff @(posedge clk) begin
		if (adv.s1) begin
			err_s1  <= error;
			derr_s1 <= derr_in;
		end
	end

	// stage 2: gain products, kept as magnitude and sign for the truncating divide
	assign prop_prod = $signed({{(PPROD_W-GAIN_W){1'b0}}, prop_gain})
		* $signed({{(PPROD_W-ERR_W){err_s1[ERR_W-1]}}, err_s1});
	assign deriv_prod = $signed({{(DPROD_W-GAIN_W){1'b0}}, deriv_gain})
		* $signed({{(DPROD_W-DERR_W){derr_s1[DERR_W-1]}}, derr_s1});
	assign prop_mag  = prop_prod[PPROD_W-1] ? MAG_W'(-prop_prod) : MAG_W'(prop_prod);
	assign deriv_mag = deriv_prod[DPROD_W-1] ? MAG_W'(-deriv_prod) : MAG_W'(deriv_prod);

	always_ff @(posedge clk) begin
		if (adv.s2) begin
			prop_mag_s2  <= prop_mag;
			deriv_mag_s2 <= deriv_mag;
			prop_neg_s2  <= prop_prod[PPROD_W-1];
			deriv_neg_s2 <= deriv_prod[DPROD_W-1];
		end
	end

	// stage 3: divide magnitudes by 100 through the reciprocal
	assign prop_scaled  = {{RECIP_W{1'b0}}, prop_mag_s2} * {{MAG_W{1'b0}}, RECIP};
	assign deriv_scaled = {{RECIP_W{1'b0}}, deriv_mag_s2} * {{MAG_W{1'b0}}, RECIP};

	always_ff @(posedge clk) begin
		if (adv.s3) begin
			prop_quot_s3  <= prop_scaled[RECIP_SHIFT +: QUOT_W];
			deriv_quot_s3 <= deriv_scaled[RECIP_SHIFT +: QUOT_W];
			prop_neg_s3   <= prop_neg_s2;
			deriv_neg_s3  <= deriv_neg_s2;
		end
	end

	// stage 4: restore signs and sum the two terms
	assign prop_term  = prop_neg_s3 ? -$signed({1'b0, prop_quot_s3})
		: $signed({1'b0, prop_quot_s3});
	assign deriv_term = deriv_neg_s3 ? -$signed({1'b0, deriv_quot_s3})
		: $signed({1'b0, deriv_quot_s3});
	assign cmd = {prop_term[TERM_W-1], prop_term} + {deriv_term[TERM_W-1], deriv_term};

	always_ff @(posedge clk) begin
		if (adv.s4) begin
			cmd_s4 <= cmd;
		end
	end

	// result stage: slew clamp against the kept speed, then speed clamp
	assign diff = {cmd_s4[CMD_W-1], cmd_s4}
		- {{(DIFF_W-DRIVE_W){speed_q[DRIVE_W-1]}}, speed_q};
	assign accel_pos = $signed({{(DIFF_W-ACCEL_W){1'b0}}, accel_limit});
	assign limit_pos = $signed({{(SUM_W-LIMIT_W){1'b0}}, speed_limit});

	always_comb begin
		if (diff > accel_pos) begin
			step = accel_pos[STEP_W-1:0];
		end else if (diff < -accel_pos) begin
			step = STEP_W'(-accel_pos);
		end else begin
			step = diff[STEP_W-1:0];
		end
	end

	assign speed_sum = {{(SUM_W-DRIVE_W){speed_q[DRIVE_W-1]}}, speed_q}
		+ {step[STEP_W-1], step};

	always_comb begin
		if (speed_sum > limit_pos) begin
			speed_next = limit_pos[DRIVE_W-1:0];
		end else if (speed_sum < -limit_pos) begin
			speed_next = DRIVE_W'(-limit_pos);
		end else begin
			speed_next = speed_sum[DRIVE_W-1:0];
		end
	end

	// the result register doubles as the kept speed
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			speed_q <= '0;
		end else if (adv.res) begin
			speed_q <= speed_next;
		end
	end

	assign drive = speed_q;

endmodule

[dv/tb.sv]
// self-checking testbench for the slew-limited pd controller with register phases and stalls
module tb;
	import pdcsl_pkg::*;

	localparam int unsigned SETTLE_CYCLES  = 10;
	localparam int unsigned LONG_HOLD      = 60;
	localparam int unsigned WATCHDOG_LIMIT = 1000;
	localparam int unsigned PHASES         = 19;
	localparam int unsigned PHASE_ITEMS    = 50;
	localparam longint      GAIN_SCALE     = 100;

	typedef enum logic [1:0] {OP_ITEM, OP_WRITE, OP_DRAIN} plan_kind_e;

	typedef struct packed {
		plan_kind_e                kind;
		logic [CFG_IDX_W-1:0]      idx;
		logic [CFG_DATA_W-1:0]     data;
		logic signed [ERR_W-1:0]   ex;
		logic signed [ERR_W-1:0]   ey;
	} plan_op_t;

	typedef struct packed {
		logic signed [DRIVE_W-1:0] dx;
		logic signed [DRIVE_W-1:0] dy;
	} drive_pair_t;

	logic                         clk       = 1'b0;
	logic                         arst_n    = 1'b0;
	logic                         cfg_wr_en = 1'b0;
	logic [CFG_IDX_W-1:0]         cfg_index = '0;
	logic [CFG_DATA_W-1:0]        cfg_data  = '0;
	logic                         in_valid  = 1'b0;
	logic                         in_stall;
	logic signed [ERR_W-1:0]      error_x   = '0;
	logic signed [ERR_W-1:0]      error_y   = '0;
	logic                         out_valid;
	logic                         out_stall = 1'b0;
	logic signed [DRIVE_W-1:0]    drive_x;
	logic signed [DRIVE_W-1:0]    drive_y;

	pd_controller_slew_limited dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wr_en (cfg_wr_en),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.error_x   (error_x),
		.error_y   (error_y),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.drive_x   (drive_x),
		.drive_y   (drive_y)
	);

	always #5 clk = ~clk;

	// shadow registers and controller state
	logic [GAIN_W-1:0]          kp      = PROP_GAIN_RST;
	logic [GAIN_W-1:0]          kd      = DERIV_GAIN_RST;
	logic [ACCEL_W-1:0]         accel   = ACCEL_LIMIT_RST;
	logic [LIMIT_W-1:0]         vmax    = SPEED_LIMIT_RST;
	logic signed [ERR_W-1:0]    last_ex = '0;
	logic signed [ERR_W-1:0]    last_ey = '0;
	logic signed [DRIVE_W-1:0]  speed_x = '0;
	logic signed [DRIVE_W-1:0]  speed_y = '0;

	plan_op_t    plan_q[$];
	drive_pair_t expected_drive_q[$];

	int unsigned in_flight    = 0;
	int unsigned send_gap     = 0;
	int unsigned settle       = 0;
	int unsigned recv_hold    = 0;
	int unsigned results_seen = 0;
	int unsigned idle_cycles  = 0;
	int unsigned errors       = 0;
	bit          send_calm    = 1'b0;
	bit          recv_calm    = 1'b0;

	function automatic longint clamp_mag(input longint v, input longint lim);
		if (v > lim)
			return lim;
		if (v < -lim)
			return -lim;
		return v;
	endfunction

	// pd command, then slew limit on the step, then speed limit
	function automatic logic signed [DRIVE_W-1:0] slewed_speed(
		input logic signed [ERR_W-1:0]   err,
		input logic signed [ERR_W-1:0]   last_err,
		input logic signed [DRIVE_W-1:0] last_speed
	);
		longint cmd;
		longint step;
		cmd = (longint'(kp) * longint'(err)) / GAIN_SCALE
			+ (longint'(kd) * (longint'(err) - longint'(last_err))) / GAIN_SCALE;
		step = clamp_mag(cmd - longint'(last_speed), longint'(accel));
		return DRIVE_W'(clamp_mag(longint'(last_speed) + step, longint'(vmax)));
	endfunction

	function automatic int unsigned pick_wait(input bit calm);
		return calm ? 0 : $urandom_range(0, 6);
	endfunction

	function automatic logic signed [ERR_W-1:0] pick_error(
		input int unsigned style,
		input logic signed [ERR_W-1:0] last
	);
		case (style)
		0: return ERR_W'($urandom);
		1: return ERR_W'(int'($urandom_range(0, 800)) - 400);
		2: begin
			case ($urandom_range(0, 3))
			0: return 16'sh7FFF;
			1: return 16'sh8000;
			2: return '0;
			default: return '1;
			endcase
		end
		default: return ERR_W'(int'(last) + int'($urandom_range(0, 120)) - 60);
		endcase
	endfunction

	// all-ones is wider than the narrow registers, so it also checks the masking
	function automatic logic [CFG_DATA_W-1:0] draw_register_value(
		input logic [CFG_IDX_W-1:0] idx
	);
		case ($urandom_range(0, 4))
		0: return '0;
		1: return '1;
		2: return (idx == REG_ACCEL_LIMIT) ? CFG_DATA_W'($urandom_range(0, 40))
			: CFG_DATA_W'($urandom_range(0, 1023));
		default: return CFG_DATA_W'($urandom_range(0, 1023));
		endcase
	endfunction

	task automatic add_item(input logic signed [ERR_W-1:0] ex, input logic signed [ERR_W-1:0] ey);
		plan_op_t op;
		op = '0;
		op.kind = OP_ITEM;
		op.ex = ex;
		op.ey = ey;
		plan_q.push_back(op);
	endtask

	task automatic add_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
		plan_op_t op;
		op = '0;
		op.kind = OP_WRITE;
		op.idx = idx;
		op.data = data;
		plan_q.push_back(op);
	endtask

	task automatic add_drain();
		plan_op_t op;
		op = '0;
		op.kind = OP_DRAIN;
		plan_q.push_back(op);
	endtask

	// sender: offers items and register writes, predicts the drive of each accepted item
	always @(posedge clk) begin : sender
		logic                       nv;
		logic                       nw;
		logic signed [ERR_W-1:0]    nex;
		logic signed [ERR_W-1:0]    ney;
		logic [CFG_IDX_W-1:0]       nidx;
		logic [CFG_DATA_W-1:0]      ndata;
		plan_op_t                   op;
		drive_pair_t                want;
		nv = in_valid;
		nw = 1'b0;
		nex = error_x;
		ney = error_y;
		nidx = cfg_index;
		ndata = cfg_data;
		if (arst_n) begin
			if (out_valid && !out_stall)
				in_flight--;
			if (in_valid && !in_stall) begin
				want.dx = slewed_speed(error_x, last_ex, speed_x);
				want.dy = slewed_speed(error_y, last_ey, speed_y);
				last_ex = error_x;
				last_ey = error_y;
				speed_x = want.dx;
				speed_y = want.dy;
				expected_drive_q.push_back(want);
				in_flight++;
				nv = 1'b0;
				send_gap = pick_wait(send_calm);
				if ($urandom_range(0, 39) == 0)
					send_calm = !send_calm;
			end
			if (!nv) begin
				if (send_gap != 0) begin
					send_gap--;
				end else if (plan_q.size() != 0) begin
					op = plan_q[0];
					case (op.kind)
					OP_ITEM: begin
						nv = 1'b1;
						nex = op.ex;
						ney = op.ey;
						void'(plan_q.pop_front());
					end
					OP_WRITE: begin
						nw = 1'b1;
						nidx = op.idx;
						ndata = op.data;
						case (op.idx)
						REG_PROP_GAIN:   kp = op.data[GAIN_W-1:0];
						REG_DERIV_GAIN:  kd = op.data[GAIN_W-1:0];
						REG_ACCEL_LIMIT: accel = op.data[ACCEL_W-1:0];
						REG_SPEED_LIMIT: vmax = op.data[LIMIT_W-1:0];
						endcase
						void'(plan_q.pop_front());
					end
					default: begin
						// hold back until every drive is in and the pipeline has settled
						if (in_flight != 0) begin
							settle = 0;
						end else if (settle < SETTLE_CYCLES) begin
							settle++;
						end else begin
							settle = 0;
							void'(plan_q.pop_front());
						end
					end
					endcase
				end
			end
		end
		in_valid <= nv;
		error_x <= nex;
		error_y <= ney;
		cfg_wr_en <= nw;
		cfg_index <= nidx;
		cfg_data <= ndata;
	end

	// receiver: stalls at random, checks each drive against the oldest prediction
	always @(posedge clk) begin : receiver
		logic        ns;
		drive_pair_t want;
		ns = out_stall;
		if (arst_n) begin
			if (out_valid && !out_stall) begin
				results_seen++;
				if (expected_drive_q.size() == 0) begin
					$error("unexpected item: drive_x %0d drive_y %0d", drive_x, drive_y);
					errors++;
				end else begin
					want = expected_drive_q.pop_front();
					if (drive_x !== want.dx) begin
						$error("drive_x: expected %0d, got %0d", want.dx, drive_x);
						errors++;
					end
					if (drive_y !== want.dy) begin
						$error("drive_y: expected %0d, got %0d", want.dy, drive_y);
						errors++;
					end
				end
				// long hold-offs mid-phase so that the pipeline fills and stalls the input
				if (results_seen == 150 || results_seen == 600)
					recv_hold = LONG_HOLD;
				else
					recv_hold = pick_wait(recv_calm);
				if ($urandom_range(0, 39) == 0)
					recv_calm = !recv_calm;
			end
			if (recv_hold != 0) begin
				recv_hold--;
				ns = 1'b1;
			end else begin
				ns = 1'b0;
			end
		end
		out_stall <= ns;
	end

	always @(posedge clk) begin : watchdog
		if ((in_valid && !in_stall) || (out_valid && !out_stall))
			idle_cycles = 0;
		else
			idle_cycles++;
		if (idle_cycles == WATCHDOG_LIMIT) begin
			$display("[pd_controller_slew_limited] ERROR");
			$finish;
		end
	end

	initial begin : stimulus
		logic signed [ERR_W-1:0] lx;
		logic signed [ERR_W-1:0] ly;
		int unsigned             style;
		lx = '0;
		ly = '0;

		// reset gains: truncation toward zero and full-scale errors
		add_item(16'sd0, 16'sd0);
		add_item(-16'sd7, 16'sd7);
		add_item(16'sh7FFF, 16'sh8000);
		add_item(16'sh8000, 16'sh7FFF);

		// zero slew limit holds the kept speed
		add_drain();
		add_write(REG_ACCEL_LIMIT, '0);
		add_item(16'sd1000, -16'sd1000);

		// oversized writes keep only the register width
		add_drain();
		add_write(REG_ACCEL_LIMIT, 10'd1023);
		add_write(REG_PROP_GAIN, '1);
		add_write(REG_DERIV_GAIN, 10'd255);
		add_write(REG_SPEED_LIMIT, '1);
		add_item(16'sh7FFF, 16'sh8000);
		add_item(16'sh8000, 16'sh7FFF);
		add_item(16'sd0, 16'sd0);
		add_item(16'sd1, -16'sd1);
		add_item(-16'sd1, 16'sd1);
		add_item(16'sh7FFF, 16'sh8000);

		// speed limit lowered under the kept speed, then zero speed limit
		add_drain();
		add_write(REG_SPEED_LIMIT, 10'd5);
		add_write(REG_ACCEL_LIMIT, 10'd1);
		add_item(16'sh7FFF, 16'sh8000);
		add_item(16'sd0, 16'sd0);
		add_drain();
		add_write(REG_SPEED_LIMIT, '0);
		add_item(16'sd12345, -16'sd12345);
		add_item(16'sh8000, 16'sh7FFF);

		// zero gains, upper data bits dropped
		add_drain();
		add_write(REG_PROP_GAIN, '0);
		add_write(REG_DERIV_GAIN, 10'h300);
		add_write(REG_SPEED_LIMIT, 10'd127);
		add_write(REG_ACCEL_LIMIT, 10'd300);
		add_item(16'sd500, -16'sd500);
		add_item(16'sh8000, 16'sh7FFF);

		// smallest gains, tight slew
		add_drain();
		add_write(REG_PROP_GAIN, 10'd1);
		add_write(REG_DERIV_GAIN, 10'd1);
		add_write(REG_ACCEL_LIMIT, 10'd2);
		add_item(16'sd99, -16'sd99);
		add_item(-16'sd101, 16'sd101);
		add_item(16'sh7FFF, 16'sh7FFF);
		add_item(16'sh8000, 16'sh8000);

		for (int p = 0; p < PHASES; p++) begin
			add_drain();
			add_write(REG_PROP_GAIN, draw_register_value(REG_PROP_GAIN));
			add_write(REG_DERIV_GAIN, draw_register_value(REG_DERIV_GAIN));
			add_write(REG_ACCEL_LIMIT, draw_register_value(REG_ACCEL_LIMIT));
			add_write(REG_SPEED_LIMIT, draw_register_value(REG_SPEED_LIMIT));
			style = $urandom_range(0, 3);
			for (int i = 0; i < PHASE_ITEMS; i++) begin
				// mostly the phase's error shape, now and then another one
				lx = pick_error(($urandom_range(0, 9) < 7) ? style : $urandom_range(0, 3), lx);
				ly = pick_error(($urandom_range(0, 9) < 7) ? style : $urandom_range(0, 3), ly);
				add_item(lx, ly);
			end
		end

		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		do
			@(negedge clk);
		while (plan_q.size() != 0 || in_valid || in_flight != 0);
		repeat (SETTLE_CYCLES) @(negedge clk);

		if (errors == 0)
			$display("[pd_controller_slew_limited] OK");
		else
			$display("[pd_controller_slew_limited] ERROR");
		$finish;
	end

endmodule

[files.f]
rtl/pdcsl_pkg.sv
rtl/pdcsl_axis.sv
rtl/pd_controller_slew_limited.sv
dv/tb.sv
